### sv/srle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_pkg - S-record line encoder shared definitions
// Line geometry, register indexes, character codes, sequencer states.
// ----------------------------------------------------------------------------
package srle_pkg;

  localparam int LINE_BYTES = 32;
  localparam int LINE_AW    = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int FILL_W     = $clog2(LINE_BYTES + 1);

  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MODE   = 2'd1;

  localparam logic [6:0] CH_S  = 7'h53;
  localparam logic [6:0] CH_2  = 7'h32;
  localparam logic [6:0] CH_3  = 7'h33;
  localparam logic [6:0] CH_LF = 7'h0A;
  localparam logic [6:0] CH_NUL = 7'h00;

  // count byte = address bytes + data bytes + 1
  localparam logic [7:0] CNT_EXTRA_S3 = 8'd5;
  localparam logic [7:0] CNT_EXTRA_S2 = 8'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD,
    ST_COUNT,
    ST_ADDR3,
    ST_ADDR2,
    ST_ADDR1,
    ST_ADDR0,
    ST_DATA,
    ST_SUM,
    ST_EOL
  } emit_state_t;

  typedef struct packed {
    logic [31:0]       addr;
    logic              short_rec;
    logic [FILL_W-1:0] nbytes;
    logic [7:0]        cksum;
  } line_info_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] c;
    if (nib <= 4'd9) c = 7'h30 + {3'b000, nib};
    else c = 7'h37 + {3'b000, nib};
    return c;
  endfunction

endpackage

### sv/srle_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_if - S-record line encoder channels
// Image byte, record character pair and register write channels.
// ----------------------------------------------------------------------------
interface srle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_image;
  modport source (output valid, data_byte, end_of_image, input ready);
  modport sink   (input valid, data_byte, end_of_image, output ready);
endinterface

interface srle_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] first_char;
  logic [6:0] second_char;
  logic [1:0] char_count;
  logic       line_end;
  modport source (output valid, first_char, second_char, char_count, line_end,
                  input ready);
  modport sink   (input valid, first_char, second_char, char_count, line_end,
                  output ready);
endinterface

interface srle_cfg_if import srle_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

### sv/srle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module srle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/srle_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srle_emit - record line sequencer
// Walks header, count, address, stored data, checksum and line end, one pair a beat.
// ----------------------------------------------------------------------------
module srle_emit import srle_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  line_info_t         info,
  output logic               busy,
  output logic [LINE_AW-1:0] raddr,
  input  logic [7:0]         rdata,
  srle_out_if.source         record
);

  emit_state_t       state, state_next;
  logic [31:0]       addr;
  logic              short_rec;
  logic [FILL_W-1:0] nbytes;
  logic [7:0]        cksum;
  logic [FILL_W-1:0] rd_idx, rd_idx_next;
  logic              fire;
  logic              last_data;
  logic [7:0]        count_byte;
  logic [7:0]        hex_val;
  logic [7:0]        sum_add;
  logic [6:0]        pair_first, pair_second;
  logic [1:0]        pair_cnt;
  logic              pair_end;

  assign busy       = (state != ST_IDLE);
  assign fire       = busy && (!record.valid || record.ready);
  assign last_data  = (rd_idx == nbytes - FILL_W'(1));
  assign count_byte = 8'(nbytes) + (short_rec ? CNT_EXTRA_S2 : CNT_EXTRA_S3);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_HEAD;
      ST_HEAD:  if (fire) state_next = ST_COUNT;
      ST_COUNT: if (fire) state_next = short_rec ? ST_ADDR2 : ST_ADDR3;
      ST_ADDR3: if (fire) state_next = ST_ADDR2;
      ST_ADDR2: if (fire) state_next = ST_ADDR1;
      ST_ADDR1: if (fire) state_next = ST_ADDR0;
      ST_ADDR0: if (fire) state_next = ST_DATA;
      ST_DATA:  if (fire && last_data) state_next = ST_SUM;
      ST_SUM:   if (fire) state_next = ST_EOL;
      ST_EOL:   if (fire) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    hex_val = 8'h00;
    sum_add = 8'h00;
    unique case (state)
      ST_COUNT: begin hex_val = count_byte;  sum_add = count_byte;  end
      ST_ADDR3: begin hex_val = addr[31:24]; sum_add = addr[31:24]; end
      ST_ADDR2: begin hex_val = addr[23:16]; sum_add = addr[23:16]; end
      ST_ADDR1: begin hex_val = addr[15:8];  sum_add = addr[15:8];  end
      ST_ADDR0: begin hex_val = addr[7:0];   sum_add = addr[7:0];   end
      ST_DATA:  hex_val = rdata;
      ST_SUM:   hex_val = ~cksum;
      default:  hex_val = 8'h00;
    endcase
  end

  always_comb begin
    pair_first  = hex_char(hex_val[7:4]);
    pair_second = hex_char(hex_val[3:0]);
    pair_cnt    = 2'd2;
    pair_end    = 1'b0;
    unique case (state)
      ST_HEAD: begin
        pair_first  = CH_S;
        pair_second = short_rec ? CH_2 : CH_3;
      end
      ST_EOL: begin
        pair_first  = CH_LF;
        pair_second = CH_NUL;
        pair_cnt    = 2'd1;
        pair_end    = 1'b1;
      end
      default: ;
    endcase
  end

  // store is read every cycle at rd_idx_next, so the registered rdata tracks the entry at rd_idx
  always_comb begin
    rd_idx_next = rd_idx;
    if (state == ST_IDLE) rd_idx_next = '0;
    else if (state == ST_DATA && fire) rd_idx_next = rd_idx + FILL_W'(1);
  end
  assign raddr = rd_idx_next[LINE_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      record.valid <= 1'b0;
      rd_idx       <= '0;
    end else begin
      state  <= state_next;
      rd_idx <= rd_idx_next;
      if (fire) record.valid <= 1'b1;
      else if (record.ready) record.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      addr      <= info.addr;
      short_rec <= info.short_rec;
      nbytes    <= info.nbytes;
      cksum     <= info.cksum;
    end else if (fire) begin
      cksum <= cksum + sum_add;
    end
    if (fire) begin
      record.first_char  <= pair_first;
      record.second_char <= pair_second;
      record.char_count  <= pair_cnt;
      record.line_end    <= pair_end;
    end
  end

endmodule

### sv/srecord_line_encoder.sv
`timescale 1ns / 1ps
// The first pair of a line is registered in the header state, entered after its last byte is taken.
// Throughput: one byte a cycle while a line fills; a line of n bytes then yields
// n+8 pairs (n+7 in S2 form) at one a cycle while the receiver holds ready high.
// Image bytes are held off while a line is being emitted.
// Reset clears counters, offsets, registers and the sequencer; the line store is
// not cleared, as only entries written in the current line are read.
// ----------------------------------------------------------------------------
// srecord_line_encoder - Motorola S3/S2 record line encoder
// Collects image bytes into a line store and emits each line as ASCII pairs.
// ----------------------------------------------------------------------------
module srecord_line_encoder import srle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  srle_in_if.sink    image,
  srle_out_if.source record,
  srle_cfg_if.sink   cfg
);

  logic [31:0]        base_address;
  logic               short_address_mode;
  logic [FILL_W-1:0]  fill_count;
  logic [31:0]        image_offset;
  logic [31:0]        line_start_offset;
  logic [7:0]         running_sum;
  logic               take;
  logic               line_done;
  logic               busy;
  logic [31:0]        line_addr;
  logic [31:0]        start_off;
  logic [7:0]         sum_next;
  logic [LINE_AW-1:0] raddr;
  logic [7:0]         rdata;
  line_info_t         info;

  assign cfg.ready   = 1'b1;
  assign image.ready = !busy;
  assign take        = image.valid && image.ready;
  assign line_done   = image.end_of_image ||
                       (fill_count == FILL_W'(LINE_BYTES - 1));
  assign start_off   = (fill_count == '0) ? image_offset : line_start_offset;
  assign line_addr   = base_address + start_off;
  assign sum_next    = running_sum + image.data_byte;

  always_comb begin
    info.addr      = line_addr;
    info.short_rec = short_address_mode && (line_addr[31:24] == 8'h00);
    info.nbytes    = fill_count + FILL_W'(1);
    info.cksum     = sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address       <= '0;
      short_address_mode <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_BASE_ADDRESS: base_address       <= cfg.wdata;
        REG_SHORT_MODE:   short_address_mode <= cfg.wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count        <= '0;
      image_offset      <= '0;
      line_start_offset <= '0;
      running_sum       <= '0;
    end else if (take) begin
      line_start_offset <= start_off;
      if (line_done) begin
        fill_count  <= '0;
        running_sum <= '0;
      end else begin
        fill_count  <= fill_count + FILL_W'(1);
        running_sum <= sum_next;
      end
      // a new image restarts at the base address
      image_offset <= image.end_of_image ? 32'd0 : image_offset + 32'd1;
    end
  end

  srle_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES),
    .AW    (LINE_AW)
  ) u_line_store (
    .clk   (clk),
    .we    (take),
    .waddr (fill_count[LINE_AW-1:0]),
    .wdata (image.data_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  srle_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .start  (take && line_done),
    .info   (info),
    .busy   (busy),
    .raddr  (raddr),
    .rdata  (rdata),
    .record (record)
  );

endmodule

### bench/tb_srecord_line_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_srecord_line_encoder - self-checking bench for the S-record line encoder
// Feeds images byte by byte under random back-pressure and register settings,
// predicts every record character pair and compares each beat as it leaves.
// ----------------------------------------------------------------------------
module tb_srecord_line_encoder;
  import srle_pkg::*;

  // indexes with no register behind them; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int RANDOM_BYTES = 140;

  typedef struct {
    logic [6:0] first_char;
    logic [6:0] second_char;
    logic [1:0] char_count;
    logic       line_end;
  } char_pair_t;

  class srec_scoreboard;
    char_pair_t  pending[$];
    logic [7:0]  line_bytes[$];
    logic [31:0] image_offset;
    logic [31:0] line_start;
    logic [31:0] base_address;
    logic        short_mode;
    logic [7:0]  data_sum;
    int          errors;

    function new();
      image_offset = '0;
      line_start   = '0;
      base_address = '0;
      short_mode   = 1'b0;
      data_sum     = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      if (idx == REG_BASE_ADDRESS) base_address = val;
      else if (idx == REG_SHORT_MODE) short_mode = val[0];
    endfunction

    function logic [6:0] hex_ascii(logic [3:0] nib);
      // '0'..'9' then 'A'..'F'
      return (nib < 4'd10) ? 7'h30 + 7'(nib) : 7'h41 + 7'(nib) - 7'd10;
    endfunction

    function void push_hex(logic [7:0] b);
      pending.push_back('{hex_ascii(b[7:4]), hex_ascii(b[3:0]), 2'd2, 1'b0});
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [31:0] addr;
      logic [7:0]  cksum;
      logic        s2;
      int          n;
      if (line_bytes.size() == 0) line_start = image_offset;
      line_bytes.push_back(b);
      data_sum     = data_sum + b;
      image_offset = image_offset + 32'd1;
      if (line_bytes.size() < LINE_BYTES && !last) return;

      n    = line_bytes.size();
      addr = base_address + line_start;
      s2   = short_mode && (addr[31:24] == 8'h00);
      pending.push_back('{CH_S, s2 ? CH_2 : CH_3, 2'd2, 1'b0});
      cksum = (s2 ? CNT_EXTRA_S2 : CNT_EXTRA_S3) + 8'(n);
      push_hex(cksum);
      if (!s2) begin
        push_hex(addr[31:24]);
        cksum = cksum + addr[31:24];
      end
      push_hex(addr[23:16]);
      push_hex(addr[15:8]);
      push_hex(addr[7:0]);
      cksum = cksum + addr[23:16] + addr[15:8] + addr[7:0];
      foreach (line_bytes[i]) push_hex(line_bytes[i]);
      cksum = cksum + data_sum;
      push_hex(~cksum);
      pending.push_back('{CH_LF, CH_NUL, 2'd1, 1'b1});

      line_bytes.delete();
      data_sum = '0;
      if (last) begin
        image_offset = '0;
        line_start   = '0;
      end else begin
        line_start = image_offset;
      end
    endfunction

    function void check_pair(logic [6:0] fc, logic [6:0] sc, logic [1:0] cnt, logic le);
      char_pair_t want;
      if (pending.size() == 0) begin
        $error("record beat with nothing expected: %h %h %0d %b", fc, sc, cnt, le);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (fc !== want.first_char) begin
        $error("first_char: expected %h, got %h", want.first_char, fc);
        errors++;
      end
      if (sc !== want.second_char) begin
        $error("second_char: expected %h, got %h", want.second_char, sc);
        errors++;
      end
      if (cnt !== want.char_count) begin
        $error("char_count: expected %0d, got %0d", want.char_count, cnt);
        errors++;
      end
      if (le !== want.line_end) begin
        $error("line_end: expected %b, got %b", want.line_end, le);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  srle_in_if  img_if();
  srle_out_if rec_if();
  srle_cfg_if cfg_if();

  srecord_line_encoder dut (
    .clk    (clk),
    .rst    (rst),
    .image  (img_if),
    .record (rec_if),
    .cfg    (cfg_if)
  );

  srec_scoreboard sb = new();

  bit no_idle;      // both sides run flat out
  bit burst;        // sender only runs flat out
  int hold_cycles;  // receiver hold-off request
  int items_sent;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 0;
    if (r < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'hFFFF_FFF0;
      3: return 32'h00FF_FFF0;
      4: return 32'h00FF_FFFF;
      5: return 32'h0100_0000;
      default: return $urandom;
    endcase
  endfunction

  // receiver: random stalls, steady stretches, and one long hold-off on request
  initial begin
    rec_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        rec_if.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (no_idle) begin
        rec_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        rec_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        rec_if.ready <= 1'b0;
        repeat (($urandom_range(0, 9) < 7) ? $urandom_range(1, 3)
                                           : $urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rec_if.valid && rec_if.ready)
      sb.check_pair(rec_if.first_char, rec_if.second_char, rec_if.char_count,
                    rec_if.line_end);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    img_if.valid        <= 1'b1;
    img_if.data_byte    <= b;
    img_if.end_of_image <= last;
    @(posedge clk);
    while (!img_if.ready) @(posedge clk);
    sb.note_byte(b, last);
    items_sent++;
    gap = (no_idle || burst) ? 0 : sender_gap();
    if (gap > 0) begin
      img_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // keep_valid leaves valid up for a following write in the same burst
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val,
                           input bit keep_valid);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_reg(idx, val);
    if (!keep_valid) cfg_if.valid <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] base, input logic short_sel);
    write_reg(REG_BASE_ADDRESS, base, 1'b1);
    write_reg(REG_SHORT_MODE, {31'b0, short_sel}, 1'b0);
  endtask

  // wait until all record beats are out and the sequencer has settled
  task automatic wait_drained();
    img_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int directed_items;
    int len;
    bit with_eoi;
    rst                 <= 1'b1;
    img_if.valid        <= 1'b0;
    img_if.data_byte    <= '0;
    img_if.end_of_image <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= REG_BASE_ADDRESS;
    cfg_if.wdata        <= '0;
    no_idle     = 1'b0;
    burst       = 1'b0;
    hold_cycles = 0;
    items_sent  = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings, single-byte images at both byte extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    wait_drained();

    // short mode with a zero top address byte gives an S2 record
    configure(32'h0012_3456, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h0F, 1'b1);
    wait_drained();

    // short mode but top byte set: stays S3
    configure(32'hFF00_0000, 1'b1);
    send_byte(8'h80, 1'b1);
    wait_drained();

    // registers changed while a partial line is held are taken at emission
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b0);
    wait_drained();
    configure(32'hDEAD_BEEF, 1'b0);
    send_byte(8'h7F, 1'b1);
    wait_drained();

    // writes to unused indexes are ignored
    write_reg(REG_SPARE_2, 32'hFFFF_FFFF, 1'b1);
    write_reg(REG_SPARE_3, 32'h0000_0001, 1'b0);
    send_byte(8'h3C, 1'b1);
    wait_drained();

    // long receiver hold-off while the sender streams, to back the block up
    configure(32'h00FF_FFE0, 1'b1);
    burst       = 1'b1;
    hold_cycles = 300;
    for (int i = 0; i < 80; i++) send_byte(8'($urandom), i == 79);
    burst = 1'b0;
    wait_drained();
    directed_items = items_sent;

    while (items_sent - directed_items < RANDOM_BYTES) begin
      if ($urandom_range(0, 2) != 0) configure(pick_base(), 1'($urandom));
      if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE_2, $urandom, 1'b0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: len = $urandom_range(1, 33);
        6, 7, 8:          len = $urandom_range(30, 70);
        default:          len = $urandom_range(64, 96);
      endcase
      with_eoi = ($urandom_range(0, 4) != 0);
      no_idle  = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < len; i++)
        send_byte(8'($urandom), with_eoi && (i == len - 1));
      wait_drained();
      no_idle = 1'b0;
    end

    // flush whatever partial line is still held
    send_byte(8'($urandom), 1'b1);
    wait_drained();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/srle_pkg.sv
sv/srle_if.sv
sv/srle_ram.sv
sv/srle_emit.sv
sv/srecord_line_encoder.sv
bench/tb_srecord_line_encoder.sv
